FILE: rtl/core/lshs_pkg.sv
`timescale 1ns / 1ps

package lshs_pkg;

   // Frame bytes of the link setup exchange.
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ADDR_CMD  = 8'h03;
   localparam logic [7:0] CTRL_SET  = 8'h07;
   localparam logic [7:0] CTRL_UA   = 8'h03;

   // Number of bytes in the SET frame.
   localparam int FRAME_LEN = 5;
   localparam int FRAME_IDX_W = 3;

   // Input item kinds.
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // Result item kinds.
   localparam logic [1:0] RES_TX   = 2'd0;
   localparam logic [1:0] RES_CONN = 2'd1;
   localparam logic [1:0] RES_FAIL = 2'd2;

   // Configuration register map.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ATTEMPTS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT      = 1'b1;

   localparam logic [3:0]  MAX_ATTEMPTS_RESET = 4'd3;
   localparam logic [15:0] TIMEOUT_RESET      = 16'd3;

   // Commands passed from the front part to the back part.
   typedef enum logic [1:0] {
      CMD_SET  = 2'd0,
      CMD_CONN = 2'd1,
      CMD_FAIL = 2'd2
   } cmd_type;

   // Link phase, one-hot.
   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_WAIT = 4'b0010,
      PH_CONN = 4'b0100,
      PH_FAIL = 4'b1000
   } phase_type;

   // Frame hunter state, one-hot.
   typedef enum logic [4:0] {
      HUNT_FLAG = 5'b00001,
      HUNT_ADDR = 5'b00010,
      HUNT_CTRL = 5'b00100,
      HUNT_CHK  = 5'b01000,
      HUNT_SKIP = 5'b10000
   } hunt_type;

   // Byte of the SET frame at a given position.
   function automatic logic [7:0] set_frame_byte(input logic [FRAME_IDX_W-1:0] idx);
      logic [7:0] b;
      begin
         unique case (idx)
            3'd0: b = FLAG_BYTE;
            3'd1: b = ADDR_CMD;
            3'd2: b = CTRL_SET;
            3'd3: b = ADDR_CMD ^ CTRL_SET;
            3'd4: b = FLAG_BYTE;
            default: b = 8'h00;
         endcase
         return b;
      end
   endfunction

endpackage

FILE: rtl/core/lshs_ifs.sv
`timescale 1ns / 1ps

// Input channel: start commands, received bytes and time ticks.
interface lshs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

// Result channel: bytes to transmit and link status.
interface lshs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] tx_byte;
   logic       last_of_run;

   modport source (output valid, output result_kind, output tx_byte, output last_of_run,
                   input ready);
   modport sink (input valid, input result_kind, input tx_byte, input last_of_run,
                 output ready);
endinterface

FILE: rtl/core/lshs_front.sv
`timescale 1ns / 1ps

module lshs_front
   import lshs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   lshs_req_if.sink               req,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   queue_full,
   output logic                   push,
   output cmd_type                push_cmd
);

   logic [3:0]  max_attempts_ff, max_attempts_in;
   logic [15:0] timeout_ff, timeout_in;
   phase_type   phase_ff, phase_in;
   hunt_type    hunt_ff, hunt_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  chk_ff, chk_in;
   logic [3:0]  attempts_ff, attempts_in;
   logic [15:0] ticks_ff, ticks_in;
   logic [15:0] ticks_dec;
   logic        accept;
   logic        ua_ok;

   // A transaction is taken whenever the command queue has room.
   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   assign ticks_dec = (ticks_ff != 16'd0) ? (ticks_ff - 16'd1) : 16'd0;
   assign ua_ok     = (addr_ff == ADDR_CMD) && (ctrl_ff == CTRL_UA) &&
                      (chk_ff == (addr_ff ^ ctrl_ff));

   // Configuration register writes.
   always_comb begin
      max_attempts_in = max_attempts_ff;
      timeout_in      = timeout_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_ATTEMPTS: max_attempts_in = csr_wdata[3:0];
            CSR_TIMEOUT:      timeout_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   // Classify each transaction, update the link state and queue a command.
   always_comb begin
      phase_in    = phase_ff;
      hunt_in     = hunt_ff;
      addr_in     = addr_ff;
      ctrl_in     = ctrl_ff;
      chk_in      = chk_ff;
      attempts_in = attempts_ff;
      ticks_in    = ticks_ff;
      push        = 1'b0;
      push_cmd    = CMD_SET;
      if (accept) begin
         if (req.kind == KIND_START) begin
            attempts_in = 4'd1;
            ticks_in    = timeout_ff;
            hunt_in     = HUNT_FLAG;
            phase_in    = PH_WAIT;
            push        = 1'b1;
            push_cmd    = CMD_SET;
         end else if (phase_ff == PH_WAIT) begin
            if (req.kind == KIND_BYTE) begin
               unique case (hunt_ff)
                  HUNT_FLAG: begin
                     if (req.rx_byte == FLAG_BYTE) hunt_in = HUNT_ADDR;
                  end
                  HUNT_ADDR: begin
                     if (req.rx_byte != FLAG_BYTE) begin
                        addr_in = req.rx_byte;
                        hunt_in = HUNT_CTRL;
                     end
                  end
                  HUNT_CTRL: begin
                     if (req.rx_byte == FLAG_BYTE) begin
                        hunt_in = HUNT_ADDR;
                     end else begin
                        ctrl_in = req.rx_byte;
                        hunt_in = HUNT_CHK;
                     end
                  end
                  HUNT_CHK: begin
                     if (req.rx_byte == FLAG_BYTE) begin
                        hunt_in = HUNT_ADDR;
                     end else begin
                        chk_in  = req.rx_byte;
                        hunt_in = HUNT_SKIP;
                     end
                  end
                  HUNT_SKIP: begin
                     // The closing flag also opens the next frame.
                     if (req.rx_byte == FLAG_BYTE) begin
                        hunt_in = HUNT_ADDR;
                        if (ua_ok) begin
                           phase_in = PH_CONN;
                           push     = 1'b1;
                           push_cmd = CMD_CONN;
                        end
                     end
                  end
                  default: hunt_in = HUNT_FLAG;
               endcase
            end else if (req.kind == KIND_TICK) begin
               ticks_in = ticks_dec;
               if (ticks_dec == 16'd0) begin
                  if (attempts_ff < max_attempts_ff) begin
                     attempts_in = attempts_ff + 4'd1;
                     ticks_in    = timeout_ff;
                     hunt_in     = HUNT_FLAG;
                     push        = 1'b1;
                     push_cmd    = CMD_SET;
                  end else begin
                     phase_in = PH_FAIL;
                     push     = 1'b1;
                     push_cmd = CMD_FAIL;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_attempts_ff <= MAX_ATTEMPTS_RESET;
         timeout_ff      <= TIMEOUT_RESET;
         phase_ff        <= PH_IDLE;
         hunt_ff         <= HUNT_FLAG;
         addr_ff         <= 8'h00;
         ctrl_ff         <= 8'h00;
         chk_ff          <= 8'h00;
         attempts_ff     <= 4'd0;
         ticks_ff        <= 16'd0;
      end else begin
         max_attempts_ff <= max_attempts_in;
         timeout_ff      <= timeout_in;
         phase_ff        <= phase_in;
         hunt_ff         <= hunt_in;
         addr_ff         <= addr_in;
         ctrl_ff         <= ctrl_in;
         chk_ff          <= chk_in;
         attempts_ff     <= attempts_in;
         ticks_ff        <= ticks_in;
      end
   end

endmodule

FILE: rtl/core/lshs_cmd_queue.sv
`timescale 1ns / 1ps

module lshs_cmd_queue
   import lshs_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = slots_ff[rd_ptr_ff];

   // Pointer and fill count updates with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/core/lshs_back.sv
`timescale 1ns / 1ps

module lshs_back
   import lshs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  cmd_type    queue_cmd,
   output logic       pop,
   lshs_rsp_if.source rsp
);

   logic                   busy_ff, busy_in;
   logic [FRAME_IDX_W-1:0] idx_ff, idx_in;
   logic                   valid_ff, valid_in;
   logic [1:0]             kind_ff, kind_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_ff, last_in;
   logic                   advance;

   // The output register may load when it is empty or being drained.
   assign advance = !valid_ff || rsp.ready;
   assign pop     = advance && !busy_ff && !queue_empty;

   // Produce one result transaction per cycle while the receiver takes them: the rest of
   // a SET frame first, then the next queued command.
   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = 1'b0;
         if (busy_ff) begin
            valid_in = 1'b1;
            kind_in  = RES_TX;
            byte_in  = set_frame_byte(idx_ff);
            last_in  = (idx_ff == FRAME_IDX_W'(FRAME_LEN - 1));
            idx_in   = idx_ff + 1'b1;
            busy_in  = (idx_ff != FRAME_IDX_W'(FRAME_LEN - 1));
         end else if (!queue_empty) begin
            valid_in = 1'b1;
            unique case (queue_cmd)
               CMD_SET: begin
                  kind_in = RES_TX;
                  byte_in = set_frame_byte('0);
                  last_in = 1'b0;
                  idx_in  = FRAME_IDX_W'(1);
                  busy_in = 1'b1;
               end
               CMD_CONN: begin
                  kind_in = RES_CONN;
                  byte_in = 8'h00;
                  last_in = 1'b1;
               end
               CMD_FAIL: begin
                  kind_in = RES_FAIL;
                  byte_in = 8'h00;
                  last_in = 1'b1;
               end
               default: begin
                  valid_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.result_kind = kind_ff;
   assign rsp.tx_byte     = byte_ff;
   assign rsp.last_of_run = last_ff;

endmodule

FILE: rtl/core/link_setup_frame_handshake_core.sv
`timescale 1ns / 1ps

// Link setup handshake, transmitter side. A start transaction makes the block send the
// SET frame 7E 03 07 04 7E as five result transactions and wait for a UA frame
// (address 03, control 03, check 00) among the received bytes; tick transactions count
// down the timeout, after which SET is sent again until max_attempts transmissions are
// used and a failure result follows. The front part takes one input transaction every
// cycle while its command queue of QUEUE_DEPTH entries has room; the back part delivers
// one result transaction per cycle while the receiver is ready, and the first result of
// an input passes through the command queue and the output register. Sustained
// throughput is bounded by that output drain rate whenever SET frames are frequent.
// Configuration writes take effect at once and should be issued while the block is idle.

module link_setup_frame_handshake_core
   import lshs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   lshs_req_if.sink               req,
   lshs_rsp_if.source             rsp,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic    queue_full;
   logic    queue_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type pop_cmd;

   // Front part: accepts and classifies transactions, keeps the link state.
   lshs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Command queue between the two parts.
   lshs_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .pop_cmd  (pop_cmd)
   );

   // Back part: turns commands into result transactions.
   lshs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_cmd   (pop_cmd),
      .pop         (pop),
      .rsp         (rsp)
   );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import lshs_pkg::*;

   // Kind code that the block does not define; it must be ignored.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] tx_byte;
      logic       last_of_run;
   } link_result_type;

   logic clock;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lshs_req_if req_ch ();
   lshs_rsp_if rsp_ch ();

   link_setup_frame_handshake_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the link setup state and its configuration.
   logic [3:0]  cfg_max_attempts;
   logic [15:0] cfg_timeout;
   phase_type   link_phase;
   hunt_type    hunt;
   logic [7:0]  seen_addr;
   logic [7:0]  seen_ctrl;
   logic [7:0]  seen_chk;
   logic [3:0]  attempts_used;
   logic [15:0] ticks_left;

   link_result_type pending_results[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int sent_items = 0;
   int burst_left = 0;
   bit sender_gaps = 1'b1;

   always #1 clock = ~clock;

   // Queue the five bytes of a SET frame and rearm the timeout.
   function automatic void queue_set_frame();
      logic [7:0] frame [5];
      frame = '{FLAG_BYTE, ADDR_CMD, CTRL_SET, ADDR_CMD ^ CTRL_SET, FLAG_BYTE};
      for (int i = 0; i < 5; i++) begin
         pending_results.push_back('{RES_TX, frame[i], i == 4});
      end
      ticks_left = cfg_timeout;
      hunt = HUNT_FLAG;
      link_phase = PH_WAIT;
   endfunction

   // Advance the frame hunter by one received byte.
   function automatic void hunt_frame(input logic [7:0] c);
      case (hunt)
         HUNT_FLAG: begin
            if (c == FLAG_BYTE) hunt = HUNT_ADDR;
         end
         HUNT_ADDR: begin
            if (c != FLAG_BYTE) begin
               seen_addr = c;
               hunt = HUNT_CTRL;
            end
         end
         HUNT_CTRL: begin
            if (c == FLAG_BYTE) hunt = HUNT_ADDR;
            else begin
               seen_ctrl = c;
               hunt = HUNT_CHK;
            end
         end
         HUNT_CHK: begin
            if (c == FLAG_BYTE) hunt = HUNT_ADDR;
            else begin
               seen_chk = c;
               hunt = HUNT_SKIP;
            end
         end
         default: begin
            // The closing flag doubles as the opening flag of the next frame.
            if (c == FLAG_BYTE) begin
               hunt = HUNT_ADDR;
               if (seen_addr == ADDR_CMD && seen_ctrl == CTRL_UA &&
                   seen_chk == (seen_addr ^ seen_ctrl)) begin
                  link_phase = PH_CONN;
                  pending_results.push_back('{RES_CONN, 8'h00, 1'b1});
               end
            end
         end
      endcase
   endfunction

   // Apply one accepted transaction; returns 1 unless the block ignores it.
   function automatic bit predict_link(input logic [1:0] kind, input logic [7:0] c);
      if (kind == KIND_START) begin
         attempts_used = 4'd1;
         queue_set_frame();
         return 1'b1;
      end
      if (link_phase != PH_WAIT) return 1'b0;
      if (kind == KIND_BYTE) begin
         hunt_frame(c);
         return 1'b1;
      end
      if (kind == KIND_TICK) begin
         if (ticks_left != 16'd0) ticks_left = ticks_left - 16'd1;
         if (ticks_left == 16'd0) begin
            if (attempts_used < cfg_max_attempts) begin
               attempts_used = attempts_used + 4'd1;
               queue_set_frame();
            end else begin
               link_phase = PH_FAIL;
               pending_results.push_back('{RES_FAIL, 8'h00, 1'b1});
            end
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Send one input transaction, with bursts and random gaps on the sender side.
   task automatic send_item(input logic [1:0] kind, input logic [7:0] rx_val);
      if (burst_left == 0) begin
         if (sender_gaps) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 5) == 0) sender_gaps = !sender_gaps;
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.kind = kind;
      req_ch.rx_byte = rx_val;
      do @(posedge clock); while (!req_ch.ready);
      void'(predict_link(kind, rx_val));
      sent_items++;
      burst_left--;
   endtask

   // Stop sending and wait until every expected result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write a configuration register once the block has gone quiet.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == CSR_MAX_ATTEMPTS) cfg_max_attempts = value[3:0];
      else cfg_timeout = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // A received byte, sometimes preceded by a tick.
   task automatic send_rx_byte(input logic [7:0] v);
      if ($urandom_range(0, 7) == 0) send_item(KIND_TICK, 8'($urandom));
      send_item(KIND_BYTE, v);
   endtask

   // A framed answer, optionally with a doubled opening flag and filler bytes.
   task automatic send_frame(input logic [7:0] a, input logic [7:0] c, input logic [7:0] k);
      send_rx_byte(FLAG_BYTE);
      if ($urandom_range(0, 3) == 0) send_rx_byte(FLAG_BYTE);
      send_rx_byte(a);
      send_rx_byte(c);
      send_rx_byte(k);
      repeat ($urandom_range(0, 2)) send_rx_byte(8'($urandom));
      send_rx_byte(FLAG_BYTE);
   endtask

   // Byte sequences from the directed tests.
   task automatic send_bytes(input logic [7:0] seq [$]);
      foreach (seq[i]) send_item(KIND_BYTE, seq[i]);
   endtask

   // Reset configuration: bytes while idle are dropped, a UA frame with a
   // doubled opening flag connects, and later ticks and unknown kinds are ignored.
   task automatic test_reset_connect();
      send_item(KIND_BYTE, FLAG_BYTE);
      send_item(KIND_START, 8'h00);
      send_bytes('{FLAG_BYTE, FLAG_BYTE, ADDR_CMD, CTRL_UA, 8'h00, FLAG_BYTE});
      send_item(KIND_TICK, 8'hFF);
      send_item(KIND_UNUSED, 8'hA5);
   endtask

   // A zero attempt limit and a zero timeout fail on the very first tick.
   task automatic test_zero_settings();
      write_register(CSR_MAX_ATTEMPTS, 16'd0);
      write_register(CSR_TIMEOUT, 16'd0);
      send_item(KIND_START, 8'h5A);
      send_item(KIND_TICK, 8'h00);
   endtask

   // Largest settings: flags in place of control and check abandon the frame,
   // a bad check is dropped and its closing flag opens the connecting frame.
   task automatic test_hunter_cases();
      write_register(CSR_MAX_ATTEMPTS, 16'd15);
      write_register(CSR_TIMEOUT, 16'hFFFF);
      send_item(KIND_START, 8'h00);
      send_item(KIND_TICK, 8'h00);
      send_bytes('{FLAG_BYTE, ADDR_CMD, FLAG_BYTE, ADDR_CMD, CTRL_UA, FLAG_BYTE,
                   ADDR_CMD, CTRL_UA, 8'h01, FLAG_BYTE,
                   ADDR_CMD, CTRL_UA, 8'h00, 8'hFF, FLAG_BYTE});
   endtask

   // One setup session: start, then a random mix of answers, noise and ticks.
   task automatic run_session();
      logic [7:0] a;
      logic [7:0] c;
      logic [7:0] k;
      int guard;
      send_item(KIND_START, 8'($urandom));
      repeat ($urandom_range(1, 4)) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_frame(ADDR_CMD, CTRL_UA, ADDR_CMD ^ CTRL_UA);
            4, 5: begin
               a = ADDR_CMD;
               c = CTRL_UA;
               k = ADDR_CMD ^ CTRL_UA;
               case ($urandom_range(0, 3))
                  0: a = 8'($urandom);
                  1: c = 8'($urandom);
                  2: k = 8'($urandom);
                  default: c = CTRL_SET;
               endcase
               send_frame(a, c, k);
            end
            6: repeat ($urandom_range(1, 5)) send_item(KIND_BYTE, 8'($urandom));
            7: repeat ($urandom_range(1, 4)) send_item(KIND_TICK, 8'($urandom));
            8: send_item(KIND_UNUSED, 8'($urandom));
            default: begin
               // Let the timeout run out until the block gives up.
               guard = 0;
               while (link_phase == PH_WAIT && guard < 100) begin
                  send_item(KIND_TICK, 8'($urandom));
                  guard++;
               end
            end
         endcase
      end
   endtask

   // Random sessions under several settings, the extremes among them.
   task automatic test_random_sessions();
      logic [3:0]  att;
      logic [15:0] tmo;
      int first;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               att = 4'd15;
               tmo = 16'd1;
            end
            1: begin
               att = 4'd1;
               tmo = 16'($urandom_range(1, 4));
            end
            2: begin
               att = 4'($urandom_range(0, 15));
               tmo = 16'($urandom_range(0, 6));
            end
            default: begin
               att = 4'($urandom_range(1, 15));
               tmo = 16'($urandom_range(1, 6));
            end
         endcase
         write_register(CSR_MAX_ATTEMPTS, {12'd0, att});
         write_register(CSR_TIMEOUT, tmo);
         first = sent_items;
         while (sent_items - first < 40) run_session();
      end
   endtask

   // Compare each accepted result transaction with the oldest expectation.
   always @(posedge clock) begin : result_check
      link_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("result with none expected: result_kind=%0d tx_byte=%02h last_of_run=%0d",
                   rsp_ch.result_kind, rsp_ch.tx_byte, rsp_ch.last_of_run);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.result_kind !== want.result_kind) begin
               $error("result_kind: expected %0d, actual %0d",
                      want.result_kind, rsp_ch.result_kind);
               mismatch_count++;
            end
            if (rsp_ch.tx_byte !== want.tx_byte) begin
               $error("tx_byte: expected %02h, actual %02h", want.tx_byte, rsp_ch.tx_byte);
               mismatch_count++;
            end
            if (rsp_ch.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, actual %0d",
                      want.last_of_run, rsp_ch.last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   // Receiver backpressure: windows of steady, random, periodic or heavy stalling.
   initial begin : rsp_stall
      int mode;
      int tick_no;
      rsp_ch.ready = 1'b0;
      tick_no = 0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(20, 80)) begin
            @(negedge clock);
            tick_no++;
            case (mode)
               0: rsp_ch.ready = 1'b1;
               1: rsp_ch.ready = 1'($urandom_range(0, 1));
               2: rsp_ch.ready = (tick_no % 3) != 2;
               default: rsp_ch.ready = $urandom_range(0, 5) == 0;
            endcase
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_START;
      req_ch.rx_byte = 8'h00;

      cfg_max_attempts = MAX_ATTEMPTS_RESET;
      cfg_timeout = TIMEOUT_RESET;
      link_phase = PH_IDLE;
      hunt = HUNT_FLAG;
      seen_addr = 8'h00;
      seen_ctrl = 8'h00;
      seen_chk = 8'h00;
      attempts_used = 4'd0;
      ticks_left = 16'd0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_connect();
      test_zero_settings();
      test_hunter_cases();
      test_random_sessions();

      drain_results();
      if (mismatch_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

FILE: link_setup_frame_handshake_core.f
rtl/core/lshs_pkg.sv
rtl/core/lshs_ifs.sv
rtl/core/lshs_front.sv
rtl/core/lshs_cmd_queue.sv
rtl/core/lshs_back.sv
rtl/core/link_setup_frame_handshake_core.sv
dv/testbench.sv
